@@ rtl/xte_pkg.sv @@
// Shared types, character codes and escape-text functions for the XML text escaper.
// Depends on nothing; used by the front, queue, back and top modules.
package xte_pkg;

  // Prefix text that the front attaches ahead of a byte.
  localparam logic [1:0] PRE_NONE       = 2'd0;  // no prefix
  localparam logic [1:0] PRE_AMP        = 2'd1;  // "&amp;"
  localparam logic [1:0] PRE_AMP_HASH   = 2'd2;  // "&amp;#"
  localparam logic [1:0] PRE_AMP_HASH_X = 2'd3;  // "&#x"

  // Treatment of the byte itself.
  localparam logic [1:0] BODY_NONE = 2'd0;
  localparam logic [1:0] BODY_ESC  = 2'd1;
  localparam logic [1:0] BODY_RAW  = 2'd2;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  typedef struct packed {
    logic [1:0] prefix;
    logic [1:0] body;
    logic [7:0] data;
    logic       last;
  } xte_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } xte_qstat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h37 + {4'h0, d};
    end
    return c;
  endfunction

  function automatic logic [2:0] esc_len(input logic [7:0] b);
    logic [2:0] n;
    unique case (b)
      CH_AMP:          n = 3'd5;
      CH_LT, CH_GT:    n = 3'd4;
      CH_QUOT, CH_APOS: n = 3'd6;
      default:         n = (b < CTRL_LIMIT) ? 3'd6 : 3'd1;
    endcase
    return n;
  endfunction

  // Escape text, left-justified in six byte slots.
  function automatic logic [7:0] esc_char(input logic [7:0] b, input logic [2:0] idx);
    logic [47:0] t;
    logic [47:0] s;
    unique case (b)
      CH_AMP:  t = {"&amp;", 8'h00};
      CH_LT:   t = {"&lt;", 16'h0000};
      CH_GT:   t = {"&gt;", 16'h0000};
      CH_QUOT: t = "&quot;";
      CH_APOS: t = "&apos;";
      default: begin
        if (b < CTRL_LIMIT) begin
          t = {"&#x", hex_char(b[7:4]), hex_char(b[3:0]), CH_SEMI};
        end else begin
          t = {b, 40'h0};
        end
      end
    endcase
    s = t << {idx, 3'b000};
    return s[47:40];
  endfunction

  function automatic logic [2:0] prefix_len(input logic [1:0] p);
    logic [2:0] n;
    unique case (p)
      PRE_AMP:        n = 3'd5;
      PRE_AMP_HASH:   n = 3'd6;
      PRE_AMP_HASH_X: n = 3'd3;
      default:        n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] p, input logic [2:0] idx);
    logic [47:0] t;
    logic [47:0] s;
    unique case (p)
      PRE_AMP:        t = {"&amp;", 8'h00};
      PRE_AMP_HASH:   t = "&amp;#";
      PRE_AMP_HASH_X: t = {"&#x", 24'h0};
      default:        t = 48'h0;
    endcase
    s = t << {idx, 3'b000};
    return s[47:40];
  endfunction

endpackage

@@ rtl/xte_front.sv @@
// Front of the XML text escaper: accepts bytes, tracks the look-ahead window and
// pass-through run, and issues expansion commands. Depends on xte_pkg.
module xte_front import xte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  input  logic       q_full,
  output logic       push,
  output xte_cmd_t   push_cmd
);

  logic [1:0] win_count;
  logic [1:0] win_count_next;
  logic       passthrough;
  logic       passthrough_next;
  logic       take;
  xte_cmd_t   cmd;

  assign take = in_valid && !q_full;

  always_comb begin
    cmd.prefix = PRE_NONE;
    cmd.body   = BODY_NONE;
    cmd.data   = in_byte;
    cmd.last   = end_of_string;
    win_count_next   = win_count;
    passthrough_next = passthrough;
    if (passthrough) begin
      if (end_of_string || in_byte == CH_SEMI) begin
        passthrough_next = 1'b0;
        cmd.body = BODY_ESC;
      end else begin
        cmd.body = BODY_RAW;
      end
    end else begin
      case (win_count)
        2'd0: begin
          if (in_byte == CH_AMP && !end_of_string) begin
            win_count_next = 2'd1;
          end else begin
            cmd.body = BODY_ESC;
          end
        end
        2'd1: begin
          if (in_byte == CH_HASH && !end_of_string) begin
            win_count_next = 2'd2;
          end else begin
            cmd.prefix = PRE_AMP;
            if (in_byte == CH_AMP && !end_of_string) begin
              win_count_next = 2'd1;
            end else begin
              win_count_next = 2'd0;
              cmd.body = BODY_ESC;
            end
          end
        end
        default: begin
          if (in_byte == CH_X) begin
            win_count_next   = 2'd0;
            cmd.prefix       = PRE_AMP_HASH_X;
            passthrough_next = !end_of_string;
          end else begin
            cmd.prefix = PRE_AMP_HASH;
            if (in_byte == CH_AMP && !end_of_string) begin
              win_count_next = 2'd1;
            end else begin
              win_count_next = 2'd0;
              cmd.body = BODY_ESC;
            end
          end
        end
      endcase
    end
    if (end_of_string) begin
      win_count_next   = 2'd0;
      passthrough_next = 1'b0;
    end
  end

  // Drop held-only bytes: they produce no command.
  assign push     = take && (cmd.prefix != PRE_NONE || cmd.body != BODY_NONE);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_count   <= 2'd0;
      passthrough <= 1'b0;
    end else if (take) begin
      win_count   <= win_count_next;
      passthrough <= passthrough_next;
    end
  end

endmodule

@@ rtl/xte_queue.sv @@
// Short command queue between the front and back of the XML text escaper.
// Depends on xte_pkg for the command and status types.
module xte_queue import xte_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  xte_cmd_t   push_cmd,
  input  logic       pop,
  output xte_cmd_t   head,
  output xte_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  xte_cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/xte_back.sv @@
// Back of the XML text escaper: expands queued commands into output bytes,
// one per cycle while the output is not stalled, through a registered output stage. Depends on xte_pkg.
module xte_back import xte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  xte_cmd_t   head,
  input  xte_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_done
);

  logic [2:0] idx;
  logic       in_body;
  logic       eff_body;
  logic [2:0] cur_len;
  logic [7:0] cur_char;
  logic       seg_end;
  logic       cmd_end;
  logic       advance;
  logic       emit;

  always_comb begin
    eff_body = in_body || (prefix_len(head.prefix) == 3'd0);
    if (eff_body) begin
      cur_len  = (head.body == BODY_ESC) ? esc_len(head.data) : 3'd1;
      cur_char = (head.body == BODY_ESC) ? esc_char(head.data, idx) : head.data;
    end else begin
      cur_len  = prefix_len(head.prefix);
      cur_char = prefix_char(head.prefix, idx);
    end
    seg_end = (idx == cur_len - 3'd1);
    cmd_end = seg_end && (eff_body || head.body == BODY_NONE);
  end

  assign advance = !out_valid || !out_stall;
  assign emit    = advance && !qstat.empty;
  assign pop     = emit && cmd_end;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= cur_char;
      run_last    <= cmd_end;
      string_done <= cmd_end && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
      in_body   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= !qstat.empty;
      end
      if (emit) begin
        if (cmd_end) begin
          idx     <= 3'd0;
          in_body <= 1'b0;
        end else if (seg_end) begin
          idx     <= 3'd0;
          in_body <= 1'b1;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

endmodule

@@ rtl/xml_text_escaper.sv @@
// XML text escaper, top level: front classifier, command queue, back expander.
// The first output byte of an item passes through the command queue and the back's output register.
// Output rate: one byte per cycle while out_stall is low; an item expands to 0 to 12 output bytes
// (held look-ahead bytes give none), limited by the back's one-byte output port.
// Input is taken every cycle while the command queue has room.
// Reset (rst, synchronous): clears window, pass-through run, queue and output.
module xml_text_escaper import xte_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_done
);

  // Commands from the front; each one expands to at least one byte.
  logic       push;
  xte_cmd_t   push_cmd;
  logic       pop;
  xte_cmd_t   head;
  xte_qstat_t qstat;

  // Stall the input side only when the queue is full.
  assign in_stall = qstat.full;

  // Classify each byte and track the "&" / "&#" window.
  xte_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .q_full        (qstat.full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  xte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  // Expand commands into bytes; hold the output register while stalled.
  xte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_done (string_done)
  );

  // End of string is always the last byte of its transaction's run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("string_done without run_last");

  // The queue never holds a command that expands to nothing.
  a_no_empty_cmd: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> (head.prefix != PRE_NONE || head.body != BODY_NONE))
    else $error("empty command in queue");

  // Never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");

  // A waiting result is not dropped while the output side stalls.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

endmodule

@@ tb/xml_text_escaper_checker.sv @@
`timescale 1ns / 1ps
// Checker for the XML text escaper: watches both channels, predicts the escaped bytes
// of every accepted input byte and compares them with the block's output in order.
// Depends on xte_pkg for the character codes.
module xml_text_escaper_checker import xte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       string_done,
  output int         errors,
  output int         pending,
  output int         results_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_done;
  } escaped_byte_t;

  localparam logic [127:0] HEX_ASCII = "0123456789ABCDEF";

  escaped_byte_t expected_q[$];
  logic [7:0]    run_bytes[$];
  logic [1:0]    held_count;
  logic          raw_run;
  int            mismatch_count = 0;
  int            checked_count = 0;

  assign errors          = mismatch_count;
  assign results_checked = checked_count;

  function automatic void emit_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      run_bytes.push_back(s[i]);
    end
  endfunction

  function automatic void emit_escaped(input logic [7:0] b);
    case (b)
      CH_AMP:  emit_text("&amp;");
      CH_LT:   emit_text("&lt;");
      CH_GT:   emit_text("&gt;");
      CH_QUOT: emit_text("&quot;");
      CH_APOS: emit_text("&apos;");
      default: begin
        if (b < CTRL_LIMIT) begin
          emit_text("&#x");
          run_bytes.push_back(HEX_ASCII[(15 - b[7:4]) * 8 +: 8]);
          run_bytes.push_back(HEX_ASCII[(15 - b[3:0]) * 8 +: 8]);
          run_bytes.push_back(CH_SEMI);
        end else begin
          run_bytes.push_back(b);
        end
      end
    endcase
  endfunction

  // A lone '&' that is not the final byte may open a raw run: hold it.
  function automatic void take_fresh(input logic [7:0] b, input logic last);
    if (b == CH_AMP && !last) begin
      held_count = 2'd1;
    end else begin
      emit_escaped(b);
    end
  endfunction

  function automatic void predict_escape(input logic [7:0] b, input logic last);
    escaped_byte_t e;
    run_bytes.delete();
    if (raw_run) begin
      if (last || b == CH_SEMI) begin
        raw_run = 1'b0;
        emit_escaped(b);
      end else begin
        run_bytes.push_back(b);
      end
    end else if (held_count == 2'd0) begin
      take_fresh(b, last);
    end else if (held_count == 2'd1) begin
      if (b == CH_HASH && !last) begin
        held_count = 2'd2;
      end else begin
        held_count = 2'd0;
        emit_text("&amp;");
        take_fresh(b, last);
      end
    end else begin
      held_count = 2'd0;
      if (b == CH_X) begin
        emit_text("&#x");
        raw_run = !last;
      end else begin
        emit_text("&amp;#");
        take_fresh(b, last);
      end
    end
    if (last) begin
      held_count = 2'd0;
      raw_run    = 1'b0;
    end
    for (int k = 0; k < run_bytes.size(); k++) begin
      e.data        = run_bytes[k];
      e.run_last    = (k == run_bytes.size() - 1);
      e.string_done = e.run_last && last;
      expected_q.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    mismatch_count++;
    $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
  endtask

  task automatic check_result();
    escaped_byte_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("escaped byte with nothing expected", 8'h00, out_byte);
    end else begin
      want = expected_q.pop_front();
      checked_count++;
      if (out_byte !== want.data) report_mismatch("out_byte", want.data, out_byte);
      if (run_last !== want.run_last) begin
        report_mismatch("run_last", {7'h00, want.run_last}, {7'h00, run_last});
      end
      if (string_done !== want.string_done) begin
        report_mismatch("string_done", {7'h00, want.string_done}, {7'h00, string_done});
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 2'd0;
      raw_run    = 1'b0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_escape(in_byte, end_of_string);
      if (out_valid && !out_stall) check_result();
    end
    pending <= expected_q.size();
  end

endmodule

@@ tb/xml_text_escaper_tb.sv @@
`timescale 1ns / 1ps
// Top of the XML text escaper testbench: clock, reset, byte stimulus, output stalls
// and the verdict. Depends on xte_pkg, xml_text_escaper and xml_text_escaper_checker.
module xml_text_escaper_tb import xte_pkg::*;;

  // Random string bytes after the directed strings.
  localparam int RANDOM_ITEMS = 300;
  // Bytes near the end that run with both sides streaming.
  localparam int QUIET_TAIL   = 60;
  // One long output hold, well beyond what the command queue can absorb.
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  // Slowest run: ~340 bytes x 12 output bytes, slowed by output stalls, plus gaps and the hold.
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  int checker_errors;
  int checker_pending;
  int checker_results;

  int         cycle_count = 0;
  int         items_sent = 0;
  int         strings_sent = 0;
  int         long_hold = 0;
  bit         idle_on = 1'b1;
  bit         hold_done = 1'b0;
  logic [7:0] text_q[$];

  xml_text_escaper i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .string_done  (string_done)
  );

  xml_text_escaper_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .end_of_string  (end_of_string),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .string_done    (string_done),
    .errors         (checker_errors),
    .pending        (checker_pending),
    .results_checked(checker_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d escaped bytes outstanding",
               CYCLE_LIMIT, checker_pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stall bursts, plus the one long hold that the stimulus
  // requests through long_hold. Each branch drives out_stall only at falling edges.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one byte, maybe after an idle burst, and hold it until the block takes it.
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  // Send the queued string, marking its final byte as the end of the string.
  task automatic send_queued();
    for (int i = 0; i < text_q.size(); i++) begin
      send_item(text_q[i], i == text_q.size() - 1);
    end
    strings_sent++;
    text_q.delete();
  endtask

  // Build a string from a few random pieces. Half the pieces are raw runs
  // or prefixes with random content; the rest are specials, control bytes, noise
  // and prefixes cut off before they complete.
  task automatic queue_random_string();
    int parts;
    int n;
    parts = $urandom_range(1, 4);
    repeat (parts) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          add_text("&#x");
          n = $urandom_range(0, 4);
          repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) != 0) text_q.push_back(CH_SEMI);
        end
        3: begin
          add_text("&");
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          add_text("&#");
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        5: begin
          case ($urandom_range(0, 4))
            0:       text_q.push_back(CH_AMP);
            1:       text_q.push_back(CH_LT);
            2:       text_q.push_back(CH_GT);
            3:       text_q.push_back(CH_QUOT);
            default: text_q.push_back(CH_APOS);
          endcase
        end
        6: text_q.push_back(8'($urandom_range(0, CTRL_LIMIT - 1)));
        7: text_q.push_back(8'($urandom()));
        8: text_q.push_back(8'($urandom_range(CTRL_LIMIT, 126)));
        default: begin
          // Prefix with nothing after it: "&", "&#" or "&#x".
          n = $urandom_range(1, 3);
          text_q.push_back(CH_AMP);
          if (n > 1) text_q.push_back(CH_HASH);
          if (n > 2) text_q.push_back(CH_X);
        end
      endcase
    end
  endtask

  initial begin
    int random_start;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    end_of_string = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Specials, control-byte extremes and an all-ones byte in one string.
    add_text("<>\"'");
    text_q.push_back(8'h00);
    text_q.push_back(8'h1F);
    text_q.push_back(8'hFF);
    send_queued();
    // Raw run with a control byte inside, closed by a semicolon.
    add_text("&#x");
    text_q.push_back(8'h01);
    text_q.push_back(CH_SEMI);
    send_queued();
    // Broken "&#" prefix, then a final ampersand.
    add_text("&#y&");
    send_queued();
    // Broken "&" prefix that restarts the window; string ends right on "&#x".
    add_text("&&#x");
    send_queued();
    // Lone ampersand as the whole string.
    add_text("&");
    send_queued();
    // Raw run cut short by the end of the string.
    add_text("&#x<");
    send_queued();
    // String ends on a held "&#".
    add_text("&#");
    send_queued();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      queue_random_string();
      if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL) begin
        idle_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      // Once, stop taking output for a long stretch while bytes keep coming.
      if (!hold_done && items_sent - random_start >= 120) begin
        long_hold = LONG_HOLD;
        hold_done = 1'b1;
      end
      send_queued();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (checker_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d strings; checked %0d escaped bytes.",
             items_sent, strings_sent, checker_results);
    $display("Strings mixed raw runs, broken and cut-off prefixes, control bytes, output stalls.");
    if (checker_errors == 0 && checker_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
